// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/skc_pkg.sv =====
`default_nettype none

package skc_pkg;

    localparam int NOW_W      = 32;
    localparam int SPEED_W    = 15;
    localparam int DRIVE_W    = 16;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int US_PER_MS  = 1000;

    // Holds (kick_delay_ms + 1) * 1000, at most 65536000.
    localparam int KICK_THR_W = 27;

    localparam logic [SPEED_W-1:0]    INTAKE_SPEED_RESET = 15'd8192;
    localparam logic [SPEED_W-1:0]    SHOOT_SPEED_RESET  = 15'd32767;
    localparam logic [KICK_THR_W-1:0] KICK_THR_RESET     = 27'd1001000;

    localparam logic signed [DRIVE_W-1:0] AXIS_THRESHOLD = -16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTAKE_SPEED = 2'd0,
        CFG_SHOOT_SPEED  = 2'd1,
        CFG_KICK_DELAY   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KICK_NONE = 2'd0,
        KICK_FWD  = 2'd1,
        KICK_REV  = 2'd2
    } kick_t;

    typedef struct packed {
        logic [SPEED_W-1:0]    intake_speed;
        logic [SPEED_W-1:0]    shoot_speed;
        logic [KICK_THR_W-1:0] kick_thr;
    } cfg_t;

    typedef struct packed {
        logic                      intake_button;
        logic                      low_shot_button;
        logic                      high_shot_button;
        logic signed [DRIVE_W-1:0] stick_axis;
        logic [NOW_W-1:0]          now_us;
    } ctrl_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] spinner_left;
        logic signed [DRIVE_W-1:0] spinner_right;
        kick_t                     kicker_command;
    } drive_item_t;

endpackage

`default_nettype wire

// ===== sv/skc_stream_if.sv =====
`default_nettype none

interface skc_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

// ===== sv/shooter_kicker_sequencer_top.sv =====
// Shooter and kicker sequencer.
// The ctrl channel takes one control tick per transfer: three buttons, the
// stick axis and a microsecond timestamp. The drive channel returns exactly
// one result per tick: left and right spinner drive and the kicker command.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user must
// do so only while no tick is in flight, which the block does not enforce. A
// kick delay write also forms the microsecond threshold. A tick passes the
// input register, then the result register, to drive.valid; the shot and
// manual-kick state is updated as it moves between the two, so the next tick
// sees it at once. A new tick is taken every cycle while drive is not stalled.
// If the receiver stalls, the result register holds and the input register
// still takes one more tick; ctrl.ready then drops until drive moves again.
// Reset clears the handshake state, the shot and manual-kick flags, and loads
// the register defaults (intake 8192, shoot 32767, delay 1000 ms).
`default_nettype none

module shooter_kicker_sequencer_top #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    skc_stream_if.sink                          ctrl,
    skc_stream_if.source                        drive,
    input  wire logic                           cfg_we,
    input  wire logic [skc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [skc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    skc_pkg::cfg_t        cfg;
    skc_pkg::ctrl_item_t  in_item_reg;
    skc_pkg::drive_item_t out_item_reg;
    skc_pkg::drive_item_t result;

    logic in_valid_reg;
    logic in_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic ctrl_xfer;
    logic advance;

    skc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    skc_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance    = in_valid_reg & (~out_valid_reg | drive.ready);
    assign ctrl.ready = ~in_valid_reg | advance;
    assign ctrl_xfer  = ctrl.valid & ctrl.ready;

    assign in_valid_next  = ctrl_xfer | (in_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & ~drive.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_xfer)
        begin
            in_item_reg <= ctrl.data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign drive.valid = out_valid_reg;
    assign drive.data  = out_item_reg;

endmodule

`default_nettype wire

// ===== sv/skc_cfg.sv =====
`default_nettype none

module skc_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [skc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [skc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output skc_pkg::cfg_t                         cfg
);

    logic [skc_pkg::SPEED_W-1:0]    intake_speed_reg;
    logic [skc_pkg::SPEED_W-1:0]    shoot_speed_reg;
    logic [skc_pkg::KICK_THR_W-1:0] kick_thr_reg;
    logic [skc_pkg::KICK_THR_W-1:0] kick_thr_next;

    // The kick fires when floor(elapsed / 1000) > delay, which is the same as
    // elapsed >= (delay + 1) * 1000, so the product is formed once per write.
    always_comb
    begin
        kick_thr_next = (skc_pkg::KICK_THR_W'(cfg_wdata[skc_pkg::DELAY_W-1:0])
                         + skc_pkg::KICK_THR_W'(1))
                        * skc_pkg::KICK_THR_W'(skc_pkg::US_PER_MS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intake_speed_reg <= skc_pkg::INTAKE_SPEED_RESET;
            shoot_speed_reg  <= skc_pkg::SHOOT_SPEED_RESET;
            kick_thr_reg     <= skc_pkg::KICK_THR_RESET;
        end
        else if (cfg_we)
        begin
            case (skc_pkg::cfg_idx_t'(cfg_index))
                skc_pkg::CFG_INTAKE_SPEED:
                    intake_speed_reg <= cfg_wdata[skc_pkg::SPEED_W-1:0];
                skc_pkg::CFG_SHOOT_SPEED:
                    shoot_speed_reg <= cfg_wdata[skc_pkg::SPEED_W-1:0];
                skc_pkg::CFG_KICK_DELAY:
                    kick_thr_reg <= kick_thr_next;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.intake_speed = intake_speed_reg;
    assign cfg.shoot_speed  = shoot_speed_reg;
    assign cfg.kick_thr     = kick_thr_reg;

endmodule

`default_nettype wire

// ===== sv/skc_core.sv =====
`default_nettype none

module skc_core #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire skc_pkg::ctrl_item_t  item,
    input  wire skc_pkg::cfg_t        cfg,
    output skc_pkg::drive_item_t      result
);

    localparam int NOW_BITS = (TIME_WIDTH < skc_pkg::NOW_W) ? TIME_WIDTH : skc_pkg::NOW_W;
    localparam int CMP_W    = (TIME_WIDTH > skc_pkg::KICK_THR_W) ? TIME_WIDTH
                                                                 : skc_pkg::KICK_THR_W;

    logic                  manual_active_reg;
    logic                  manual_active_next;
    logic                  low_active_reg;
    logic                  low_active_next;
    logic [TIME_WIDTH-1:0] low_start_reg;
    logic [TIME_WIDTH-1:0] low_start_next;
    logic                  high_active_reg;
    logic                  high_active_next;
    logic [TIME_WIDTH-1:0] high_start_reg;
    logic [TIME_WIDTH-1:0] high_start_next;

    logic                  lone_intake;
    logic                  lone_low;
    logic                  lone_high;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] low_elapsed;
    logic [TIME_WIDTH-1:0] high_elapsed;
    logic                  low_fire;
    logic                  high_fire;
    logic [skc_pkg::DRIVE_W-1:0] intake_pos;
    logic [skc_pkg::DRIVE_W-1:0] intake_neg;
    logic [skc_pkg::DRIVE_W-1:0] shoot_pos;
    logic [skc_pkg::DRIVE_W-1:0] shoot_neg;

    assign lone_intake = item.intake_button & ~item.low_shot_button & ~item.high_shot_button;
    assign lone_low    = item.low_shot_button & ~item.intake_button & ~item.high_shot_button;
    assign lone_high   = item.high_shot_button & ~item.intake_button & ~item.low_shot_button;

    assign now_t = TIME_WIDTH'(item.now_us[NOW_BITS-1:0]);

    // A shot that starts in this tick has zero elapsed time and cannot fire.
    assign low_elapsed  = now_t - (low_active_reg ? low_start_reg : now_t);
    assign high_elapsed = now_t - (high_active_reg ? high_start_reg : now_t);
    assign low_fire  = CMP_W'(low_elapsed) >= CMP_W'(cfg.kick_thr);
    assign high_fire = CMP_W'(high_elapsed) >= CMP_W'(cfg.kick_thr);

    assign intake_pos = {1'b0, cfg.intake_speed};
    assign intake_neg = skc_pkg::DRIVE_W'(0) - intake_pos;
    assign shoot_pos  = {1'b0, cfg.shoot_speed};
    assign shoot_neg  = skc_pkg::DRIVE_W'(0) - shoot_pos;

    // Kicker commands are evaluated in priority order, the later one winning.
    always_comb
    begin
        result.spinner_left   = '0;
        result.spinner_right  = '0;
        result.kicker_command = skc_pkg::KICK_NONE;
        manual_active_next    = manual_active_reg;
        low_active_next       = low_active_reg;
        low_start_next        = low_start_reg;
        high_active_next      = high_active_reg;
        high_start_next       = high_start_reg;

        if (lone_intake)
        begin
            result.spinner_left  = intake_neg;
            result.spinner_right = intake_pos;
        end

        if ((item.stick_axis < skc_pkg::AXIS_THRESHOLD) && !manual_active_reg)
        begin
            manual_active_next    = 1'b1;
            result.kicker_command = skc_pkg::KICK_FWD;
        end
        if ((item.stick_axis > skc_pkg::AXIS_THRESHOLD) && manual_active_reg)
        begin
            manual_active_next    = 1'b0;
            result.kicker_command = skc_pkg::KICK_REV;
        end

        if (lone_low)
        begin
            low_active_next = 1'b1;
            if (!low_active_reg)
            begin
                low_start_next = now_t;
            end
            result.spinner_left  = shoot_pos;
            result.spinner_right = shoot_neg;
            if (low_fire)
            begin
                result.kicker_command = skc_pkg::KICK_FWD;
            end
        end
        if (!item.low_shot_button && low_active_reg)
        begin
            low_active_next       = 1'b0;
            result.kicker_command = skc_pkg::KICK_REV;
        end

        if (lone_high)
        begin
            high_active_next = 1'b1;
            if (!high_active_reg)
            begin
                high_start_next = now_t;
            end
            result.spinner_left  = shoot_neg;
            result.spinner_right = shoot_pos;
            if (high_fire)
            begin
                result.kicker_command = skc_pkg::KICK_FWD;
            end
        end
        if (!item.high_shot_button && high_active_reg)
        begin
            high_active_next      = 1'b0;
            result.kicker_command = skc_pkg::KICK_REV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_active_reg <= 1'b0;
            low_active_reg    <= 1'b0;
            high_active_reg   <= 1'b0;
        end
        else if (advance)
        begin
            manual_active_reg <= manual_active_next;
            low_active_reg    <= low_active_next;
            high_active_reg   <= high_active_next;
        end
    end

    // Start times are only read while their shot is active.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            low_start_reg  <= low_start_next;
            high_start_reg <= high_start_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/skc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module skc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          ctrl_valid,
    input wire logic                          ctrl_ready,
    input wire logic                          drive_valid,
    input wire logic                          drive_ready,
    input wire logic [skc_pkg::DRIVE_W-1:0]   spinner_left,
    input wire logic [skc_pkg::DRIVE_W-1:0]   spinner_right,
    input wire logic [1:0]                    kicker_command
);

    // The spinner drives always sum to zero: opposite directions at the same magnitude, or both stopped.
    `SKC_ASSERT_SAME(a_spin_mirror, drive_valid, (spinner_left + spinner_right) == '0, "spinner drives are not mirrored")

    // The input side only backs up when a finished result is waiting.
    `SKC_ASSERT_SAME(a_stall_cause, !ctrl_ready, drive_valid && !drive_ready, "input stalled with no pending result")

    // With the receiver ready, a tick passes the input register, then the result register, to drive_valid.
    `SKC_ASSERT_NEXT(a_latency, (ctrl_valid && ctrl_ready) ##1 drive_ready, drive_valid, "result missing after two cycles")

    // A stalled result stays put.
    `SKC_ASSERT_NEXT(a_hold, drive_valid && !drive_ready, drive_valid && $stable({spinner_left, spinner_right, kicker_command}), "stalled result changed")

endmodule

bind shooter_kicker_sequencer_top skc_checker u_skc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl_valid     (ctrl.valid),
    .ctrl_ready     (ctrl.ready),
    .drive_valid    (drive.valid),
    .drive_ready    (drive.ready),
    .spinner_left   (drive.data.spinner_left),
    .spinner_right  (drive.data.spinner_right),
    .kicker_command (drive.data.kicker_command)
);

`default_nettype wire

// ===== tb/shooter_kicker_sequencer_top_tb.sv =====
`timescale 1ns / 100ps

module shooter_kicker_sequencer_top_tb;

    import skc_pkg::*;

    // Predicts the drive output of each control tick and holds the drive items that
    // have not come back yet.
    class drive_scoreboard;
        logic [SPEED_W-1:0] intake_spd;
        logic [SPEED_W-1:0] shoot_spd;
        logic [DELAY_W-1:0] delay_ms;
        bit                 manual_on;
        bit                 low_on;
        bit                 high_on;
        logic [NOW_W-1:0]   low_t0;
        logic [NOW_W-1:0]   high_t0;
        drive_item_t        drive_q[$];
        int unsigned        errors;

        function new();
            intake_spd = INTAKE_SPEED_RESET;
            shoot_spd  = SHOOT_SPEED_RESET;
            delay_ms   = 16'd1000;
            manual_on  = 1'b0;
            low_on     = 1'b0;
            high_on    = 1'b0;
            low_t0     = '0;
            high_t0    = '0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_INTAKE_SPEED: intake_spd = val[SPEED_W-1:0];
                CFG_SHOOT_SPEED:  shoot_spd  = val[SPEED_W-1:0];
                CFG_KICK_DELAY:   delay_ms   = val[DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        // The elapsed time wraps modulo 2^32 before it is cut down to whole milliseconds.
        function bit spun_up(logic [NOW_W-1:0] now, logic [NOW_W-1:0] t0);
            logic [NOW_W-1:0] elapsed;
            elapsed = now - t0;
            return (elapsed / 32'(US_PER_MS)) > {16'd0, delay_ms};
        endfunction

        function void note_tick(ctrl_item_t t);
            drive_item_t r;
            bit          only_in;
            bit          only_lo;
            bit          only_hi;
            only_in = t.intake_button && !t.low_shot_button && !t.high_shot_button;
            only_lo = t.low_shot_button && !t.intake_button && !t.high_shot_button;
            only_hi = t.high_shot_button && !t.intake_button && !t.low_shot_button;
            r.spinner_left   = '0;
            r.spinner_right  = '0;
            r.kicker_command = KICK_NONE;
            if (only_in)
            begin
                r.spinner_left  = -$signed({1'b0, intake_spd});
                r.spinner_right = $signed({1'b0, intake_spd});
            end
            if (t.stick_axis < AXIS_THRESHOLD && !manual_on)
            begin
                manual_on        = 1'b1;
                r.kicker_command = KICK_FWD;
            end
            if (t.stick_axis > AXIS_THRESHOLD && manual_on)
            begin
                manual_on        = 1'b0;
                r.kicker_command = KICK_REV;
            end
            if (only_lo)
            begin
                if (!low_on)
                begin
                    low_on = 1'b1;
                    low_t0 = t.now_us;
                end
                r.spinner_left  = $signed({1'b0, shoot_spd});
                r.spinner_right = -$signed({1'b0, shoot_spd});
                if (spun_up(t.now_us, low_t0))
                    r.kicker_command = KICK_FWD;
            end
            if (!t.low_shot_button && low_on)
            begin
                low_on           = 1'b0;
                r.kicker_command = KICK_REV;
            end
            if (only_hi)
            begin
                if (!high_on)
                begin
                    high_on = 1'b1;
                    high_t0 = t.now_us;
                end
                r.spinner_left  = -$signed({1'b0, shoot_spd});
                r.spinner_right = $signed({1'b0, shoot_spd});
                if (spun_up(t.now_us, high_t0))
                    r.kicker_command = KICK_FWD;
            end
            if (!t.high_shot_button && high_on)
            begin
                high_on          = 1'b0;
                r.kicker_command = KICK_REV;
            end
            drive_q.push_back(r);
        endfunction

        function void check_result(drive_item_t got);
            drive_item_t want;
            if (drive_q.size() == 0)
            begin
                $display("%0t: unexpected drive transfer: expected none, got %0d %0d %0d",
                         $time, got.spinner_left, got.spinner_right, got.kicker_command);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            if (got.spinner_left !== want.spinner_left)
            begin
                $display("%0t: spinner_left expected %0d, got %0d",
                         $time, want.spinner_left, got.spinner_left);
                errors++;
            end
            if (got.spinner_right !== want.spinner_right)
            begin
                $display("%0t: spinner_right expected %0d, got %0d",
                         $time, want.spinner_right, got.spinner_right);
                errors++;
            end
            if (got.kicker_command !== want.kicker_command)
            begin
                $display("%0t: kicker_command expected %0d, got %0d",
                         $time, want.kicker_command, got.kicker_command);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    skc_stream_if #(.payload_t(ctrl_item_t))  ctrl_if ();
    skc_stream_if #(.payload_t(drive_item_t)) drive_if ();

    shooter_kicker_sequencer_top #(.TIME_WIDTH(32)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_if),
        .drive     (drive_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    drive_scoreboard  sb = new();
    bit               src_calm = 1'b0;
    bit               sink_calm = 1'b0;
    int               ticks_sent = 0;
    logic [NOW_W-1:0] now_base = '0;
    logic [DELAY_W-1:0] cur_delay_ms = 16'd1000;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        drive_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            drive_if.ready <= sink_calm || ($urandom_range(99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ctrl_if.valid && ctrl_if.ready)
                sb.note_tick(ctrl_if.data);
            if (drive_if.valid && drive_if.ready)
                sb.check_result(drive_if.data);
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic ctrl_item_t make_tick(bit b_in, bit b_lo, bit b_hi,
                                             logic signed [15:0] axis, logic [31:0] now);
        ctrl_item_t t;
        t.intake_button    = b_in;
        t.low_shot_button  = b_lo;
        t.high_shot_button = b_hi;
        t.stick_axis       = axis;
        t.now_us           = now;
        return t;
    endfunction

    task automatic send_tick(input ctrl_item_t t);
        while (!src_calm && $urandom_range(99) < 32)
        begin
            ctrl_if.valid <= 1'b0;
            @(posedge clk);
        end
        ctrl_if.valid <= 1'b1;
        ctrl_if.data  <= t;
        do
            @(posedge clk);
        while (!ctrl_if.ready);
        ticks_sent++;
    endtask

    // Holds the sender off until every predicted drive item has come back. The first
    // edge lets the monitor record the last transfer.
    task automatic drain();
        ctrl_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.drive_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [14:0] intake, input logic [14:0] shoot,
                              input logic [15:0] delay);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INTAKE_SPEED;
        cfg_wdata <= {1'b0, intake};
        @(posedge clk);
        cfg_index <= CFG_SHOOT_SPEED;
        cfg_wdata <= {1'b0, shoot};
        @(posedge clk);
        cfg_index <= CFG_KICK_DELAY;
        cfg_wdata <= delay;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.write_reg(CFG_INTAKE_SPEED, {1'b0, intake});
        sb.write_reg(CFG_SHOOT_SPEED, {1'b0, shoot});
        sb.write_reg(CFG_KICK_DELAY, delay);
        cur_delay_ms = delay;
    endtask

    function automatic logic [15:0] axis_pick();
        case ($urandom_range(4))
            0, 1:    return 16'(-16385 - int'($urandom_range(16383)));
            2:       return AXIS_THRESHOLD;
            default: return 16'(-16383 + int'($urandom_range(49150)));
        endcase
    endfunction

    // A shot held for 2 to 10 ticks, usually alone, with timestamps placed around the
    // firing threshold, then usually released.
    task automatic shot_run();
        int unsigned thr;
        int unsigned offset;
        logic [31:0] t0;
        bit          high;
        int          len;
        ctrl_item_t  t;
        thr    = (int'(cur_delay_ms) + 1) * US_PER_MS;
        high   = $urandom_range(1);
        len    = $urandom_range(10, 2);
        offset = 0;
        if ($urandom_range(9) == 0)
            t0 = 32'hFFFF_FFFF - $urandom_range(thr);
        else
        begin
            now_base += $urandom_range(3_000_000);
            t0 = now_base;
        end
        for (int k = 0; k < len; k++)
        begin
            if (k > 0)
            begin
                case ($urandom_range(5))
                    0: offset = $urandom_range(thr - 1);
                    1: offset = thr - 1;
                    2: offset = thr;
                    3: offset = thr + $urandom_range(5000);
                    4: offset = $urandom;
                    default: ;
                endcase
            end
            t.intake_button    = ($urandom_range(99) < 8);
            t.low_shot_button  = !high || ($urandom_range(99) < 8);
            t.high_shot_button = high || ($urandom_range(99) < 8);
            t.stick_axis       = $urandom_range(1) ? 16'($urandom) : 16'sd0;
            t.now_us           = t0 + offset;
            send_tick(t);
        end
        now_base = t0 + offset;
        if ($urandom_range(4) != 0)
        begin
            t.intake_button    = ($urandom_range(99) < 10);
            t.low_shot_button  = high && ($urandom_range(99) < 10);
            t.high_shot_button = !high && ($urandom_range(99) < 10);
            t.stick_axis       = 16'($urandom);
            t.now_us           = now_base + $urandom_range(50000);
            send_tick(t);
        end
    endtask

    task automatic manual_run();
        ctrl_item_t t;
        int         len;
        len = $urandom_range(6, 2);
        for (int k = 0; k < len; k++)
        begin
            {t.intake_button, t.low_shot_button, t.high_shot_button} =
                ($urandom_range(3) == 0) ? 3'($urandom) : 3'b000;
            t.stick_axis = axis_pick();
            now_base += $urandom_range(20000);
            t.now_us = now_base;
            send_tick(t);
        end
    endtask

    task automatic intake_run();
        ctrl_item_t t;
        int         len;
        len = $urandom_range(5, 1);
        for (int k = 0; k < len; k++)
        begin
            t.intake_button    = 1'b1;
            t.low_shot_button  = ($urandom_range(9) == 0);
            t.high_shot_button = ($urandom_range(9) == 0);
            t.stick_axis       = 16'($urandom);
            now_base += $urandom_range(20000);
            t.now_us = now_base;
            send_tick(t);
        end
    endtask

    task automatic noise_tick();
        ctrl_item_t t;
        {t.intake_button, t.low_shot_button, t.high_shot_button} = 3'($urandom);
        t.stick_axis = 16'($urandom);
        t.now_us     = $urandom;
        send_tick(t);
    endtask

    initial
    begin
        int target;
        int pick;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_INTAKE_SPEED;
        cfg_wdata     <= '0;
        ctrl_if.valid <= 1'b0;
        ctrl_if.data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 8192 intake, full shoot speed, 1000 ms delay.
        send_tick(make_tick(0, 0, 0, 16'sd0, 32'd0));
        send_tick(make_tick(1, 0, 0, 16'sd32767, 32'd5));
        send_tick(make_tick(0, 1, 0, 16'sd0, 32'd1000));
        send_tick(make_tick(0, 1, 0, 16'sd0, 32'd1_001_999));
        send_tick(make_tick(0, 1, 0, 16'sd0, 32'd1_002_000));
        send_tick(make_tick(1, 1, 0, 16'sd0, 32'd1_003_000));
        send_tick(make_tick(0, 1, 0, 16'sd0, 32'd1_004_000));
        send_tick(make_tick(0, 0, 0, 16'sd0, 32'd1_005_000));
        send_tick(make_tick(0, 0, 1, -16'sd1, 32'h8000_0000));
        // The elapsed time wraps to just under 2^32.
        send_tick(make_tick(0, 0, 1, -16'sd1, 32'h7FFF_FFFF));
        send_tick(make_tick(0, 1, 1, 16'sd0, 32'h8000_1000));
        send_tick(make_tick(0, 0, 0, 16'sd0, 32'h8000_2000));
        send_tick(make_tick(0, 0, 0, -16'sd32768, 32'd10));
        send_tick(make_tick(0, 0, 0, -16'sd32768, 32'd11));
        send_tick(make_tick(0, 0, 0, -16'sd16384, 32'd12));
        send_tick(make_tick(0, 0, 0, -16'sd16383, 32'd13));
        send_tick(make_tick(0, 0, 0, -16'sd16384, 32'd14));
        send_tick(make_tick(0, 0, 0, -16'sd16385, 32'd15));
        send_tick(make_tick(0, 0, 0, 16'sd32767, 32'd16));
        send_tick(make_tick(1, 1, 1, 16'sd0, 32'hFFFF_FFFF));
        send_tick(make_tick(1, 0, 1, 16'sd0, 32'd0));
        // Manual forward and a low shot release in one tick: the release wins.
        send_tick(make_tick(0, 1, 0, 16'sd0, 32'd100));
        send_tick(make_tick(0, 0, 0, -16'sd20000, 32'd200));
        // Manual retract while a low shot starts, then a later low shot tick fires the kicker.
        send_tick(make_tick(0, 1, 0, 16'sd0, 32'd300));
        send_tick(make_tick(0, 1, 0, 16'sd0, 32'd2_000_300));
        send_tick(make_tick(0, 0, 0, 16'sd0, 32'd0));
        drain();

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: set_config(15'd0, 15'd0, 16'd0);
                1: set_config(15'h7FFF, 15'h7FFF, 16'hFFFF);
                2: set_config(15'($urandom), 15'($urandom), 16'd1);
                3: set_config(15'($urandom), 15'($urandom), 16'($urandom_range(20)));
                4: set_config(15'd16384, 15'd1, 16'd2);
                5: set_config(15'($urandom), 15'($urandom), 16'($urandom));
                default: set_config(15'd1, 15'h7FFF, 16'd0);
            endcase
            src_calm  = (p == 3);
            sink_calm = (p == 3);
            target = ticks_sent + 180;
            while (ticks_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                    shot_run();
                else if (pick < 55)
                    manual_run();
                else if (pick < 70)
                    intake_run();
                else
                    noise_tick();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.drive_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
